// ===== hdl/epr_pkg.sv =====
// ----------------------------------------------------------------------------
// epr_pkg
// Shared constants and controller/datapath interface types for the escaped
// packet receiver.
// ----------------------------------------------------------------------------
package epr_pkg;

	localparam int PKT_MAX_DEF = 32;

	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORDS = 2'd2;

	localparam logic [7:0] START_RST     = 8'd1;
	localparam logic [7:0] ESCAPE_RST    = 8'd27;
	localparam logic [5:0] MAX_WORDS_RST = 6'd32;

	// result kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_ACK   = 2'd1;
	localparam logic [1:0] KIND_NAK   = 2'd2;

	typedef struct packed {
		logic load_low;
		logic load_len;
		logic load_base;
		logic init_sum;
		logic store_word;
		logic load_resp;
		logic resp_ack;
		logic drain_clr;
		logic drain_next;
		logic load_wr;
	} epr_cmd_t;

	typedef struct packed {
		logic is_start;
		logic is_escape;
		logic len_over;
		logic count_done;
		logic sum_ok;
		logic len_zero;
		logic drain_last;
		logic out_free;
	} epr_stat_t;

endpackage

// ===== hdl/epr_ctrl.sv =====
// ----------------------------------------------------------------------------
// epr_ctrl
// Framing state machine: start hunt, escape handling, word phases and the
// acknowledge / write drain sequence.
// ----------------------------------------------------------------------------
module epr_ctrl import epr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rx_valid,
	output logic      rx_stall,
	input  epr_stat_t st,
	output epr_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_HUNT, S_LEN_L, S_LEN_H, S_BASE_L, S_BASE_H, S_DAT_L, S_DAT_H,
		S_SUM_L, S_SUM_H, S_RESP, S_RD, S_WR
	} state_t;

	state_t state_q;
	logic   esc_q;
	logic   ack_q;
	logic   rx_fire;
	logic   data_fire;

	assign rx_stall  = (state_q == S_RESP) || (state_q == S_RD) || (state_q == S_WR);
	assign rx_fire   = rx_valid && !rx_stall;
	// a byte that is neither the hunt byte nor a consumed escape
	assign data_fire = rx_fire && (state_q != S_HUNT) && (esc_q || !st.is_escape);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_LEN_L, S_BASE_L, S_DAT_L, S_SUM_L: begin
				cmd.load_low = data_fire;
			end
			S_LEN_H: begin
				cmd.load_len = data_fire;
			end
			S_BASE_H: begin
				cmd.load_base = data_fire;
				cmd.init_sum  = data_fire && !st.len_over;
			end
			S_DAT_H: begin
				cmd.store_word = data_fire;
			end
			S_RESP: begin
				cmd.load_resp = st.out_free;
				cmd.resp_ack  = ack_q;
				cmd.drain_clr = 1'b1;
			end
			S_WR: begin
				cmd.load_wr    = st.out_free;
				cmd.drain_next = st.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
			esc_q   <= 1'b0;
			ack_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_HUNT: begin
					if (rx_fire && st.is_start) begin
						state_q <= S_LEN_L;
						esc_q   <= 1'b0;
					end
				end
				S_LEN_L, S_LEN_H, S_BASE_L, S_BASE_H, S_DAT_L, S_DAT_H,
				S_SUM_L, S_SUM_H: begin
					if (rx_fire) begin
						if (!esc_q && st.is_escape) begin
							esc_q <= 1'b1;
						end else begin
							esc_q <= 1'b0;
							unique case (state_q)
								S_LEN_L:  state_q <= S_LEN_H;
								S_LEN_H:  state_q <= S_BASE_L;
								S_BASE_L: state_q <= S_BASE_H;
								S_BASE_H: begin
									if (st.len_over) begin
										ack_q   <= 1'b0;
										state_q <= S_RESP;
									end else if (st.len_zero) begin
										state_q <= S_SUM_L;
									end else begin
										state_q <= S_DAT_L;
									end
								end
								S_DAT_L:  state_q <= S_DAT_H;
								S_DAT_H:  state_q <= st.count_done ? S_SUM_L : S_DAT_L;
								S_SUM_L:  state_q <= S_SUM_H;
								default: begin
									ack_q   <= st.sum_ok;
									state_q <= S_RESP;
								end
							endcase
						end
					end
				end
				S_RESP: begin
					if (st.out_free) begin
						state_q <= (ack_q && !st.len_zero) ? S_RD : S_HUNT;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (st.out_free) begin
						state_q <= st.drain_last ? S_HUNT : S_RD;
					end
				end
				default: begin
					state_q <= S_HUNT;
				end
			endcase
		end
	end

	// last write of a drain returns to hunting
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR && st.out_free && st.drain_last) |=> (state_q == S_HUNT))
		else $error("drain did not end in hunt");

	// a negative acknowledge always ends the packet
	a_nak_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_resp && !cmd.resp_ack) |=> (state_q == S_HUNT))
		else $error("nak not followed by hunt");

	// no byte is taken while results are being produced
	a_no_rx_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_resp || cmd.load_wr) |-> !rx_fire)
		else $error("byte accepted during response");

endmodule

// ===== hdl/epr_dpath.sv =====
// ----------------------------------------------------------------------------
// epr_dpath
// Configuration registers, word assembly, checksum, payload buffer and the
// result output register.
// ----------------------------------------------------------------------------
module epr_dpath import epr_pkg::*; #(
	parameter int PKT_MAX = PKT_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	input  logic [7:0]           rx_byte,
	input  epr_cmd_t             cmd,
	output epr_stat_t            st,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [1:0]           kind,
	output logic [15:0]          word_addr,
	output logic [15:0]          data,
	output logic                 end_of_transfer,
	output logic                 last
);

	localparam int         CNT_W     = $clog2(PKT_MAX + 1);
	localparam int         ADDR_W    = (PKT_MAX > 1) ? $clog2(PKT_MAX) : 1;
	localparam logic [5:0] PKT_MAX_6 = 6'(PKT_MAX);

	logic [7:0]       start_q;
	logic [7:0]       escape_q;
	logic [5:0]       max_words_q;
	logic [7:0]       low_q;
	logic [15:0]      len_q;
	logic [15:0]      base_q;
	logic [15:0]      sum_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [15:0]      mem [PKT_MAX];
	logic [15:0]      rd_data_q;
	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic [15:0]      addr_q;
	logic [15:0]      data_q;
	logic             eot_q;
	logic             last_q;

	logic [15:0] w;
	logic [5:0]  lim;

	assign w   = {rx_byte, low_q};
	assign lim = (max_words_q < PKT_MAX_6) ? max_words_q : PKT_MAX_6;

	always_comb begin
		st.is_start   = (rx_byte == start_q);
		st.is_escape  = (rx_byte == escape_q);
		st.len_over   = (len_q > {10'd0, lim});
		st.count_done = ((16'(count_q) + 16'd1) >= len_q);
		st.sum_ok     = (sum_q == w);
		st.len_zero   = (len_q == 16'd0);
		st.drain_last = ((16'(idx_q) + 16'd1) >= len_q);
		st.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= START_RST;
			escape_q    <= ESCAPE_RST;
			max_words_q <= MAX_WORDS_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					CFG_START:     start_q     <= wr_data;
					CFG_ESCAPE:    escape_q    <= wr_data;
					CFG_MAX_WORDS: max_words_q <= wr_data[5:0];
					default: begin
					end
				endcase
			end
			if (cmd.load_resp || cmd.load_wr) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_low) begin
			low_q <= rx_byte;
		end
		if (cmd.load_len) begin
			len_q <= w;
		end
		if (cmd.load_base) begin
			base_q <= w;
		end
		if (cmd.init_sum) begin
			sum_q   <= len_q + w;
			count_q <= '0;
		end else if (cmd.store_word) begin
			sum_q   <= sum_q + w;
			count_q <= count_q + CNT_W'(1);
		end
		if (cmd.drain_clr) begin
			idx_q <= '0;
		end else if (cmd.drain_next) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (cmd.load_resp) begin
			kind_q <= cmd.resp_ack ? KIND_ACK : KIND_NAK;
			addr_q <= 16'd0;
			data_q <= 16'd0;
			eot_q  <= cmd.resp_ack && st.len_zero;
			last_q <= !cmd.resp_ack || st.len_zero;
		end else if (cmd.load_wr) begin
			kind_q <= KIND_WRITE;
			addr_q <= (base_q >> 1) + 16'(idx_q);
			data_q <= rd_data_q;
			eot_q  <= 1'b0;
			last_q <= st.drain_last;
		end
	end

	// payload buffer
	always_ff @(posedge clk) begin
		if (cmd.store_word && (count_q < CNT_W'(PKT_MAX))) begin
			mem[count_q[ADDR_W-1:0]] <= w;
		end
		rd_data_q <= mem[idx_q[ADDR_W-1:0]];
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign word_addr       = addr_q;
	assign data            = data_q;
	assign end_of_transfer = eot_q;
	assign last            = last_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_resp || cmd.load_wr) |-> st.out_free)
		else $error("output register overwritten");

	a_store_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_word |-> (count_q < CNT_W'(PKT_MAX)))
		else $error("payload store beyond buffer");

	a_write_no_eot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_WRITE) |-> !eot_q)
		else $error("end of transfer flagged on write");

endmodule

// ===== hdl/escaped_packet_receiver_checksum_core.sv =====
// ----------------------------------------------------------------------------
// escaped_packet_receiver_checksum_core
// Byte-stuffed packet deframer with 16-bit additive checksum and write burst.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction. While hunting, raw bytes are
// dropped until one equals start_byte; after that escape_byte marks the next
// byte as literal and little-endian words are read: length, byte base
// address, length payload words, checksum (16-bit wrapping sum of length,
// base and payload). A length above min(max_words, PKT_MAX) gives a nak at
// once, a bad checksum gives a nak, a good one gives an ack (end_of_transfer
// set when the length is zero) followed by one write per payload word at
// word address base/2 + i. last marks the final result caused by a byte.
// While framing, rx_stall stays low and every byte is taken. After the byte
// that completes a packet the input is held while the ack or nak is loaded
// into the output register, then for each payload write while the payload
// buffer is read through its read register and the output register is
// loaded, and while the output side stalls. The output register lets a result
// wait while the next byte is taken. The payload buffer needs no clearing
// after reset: every entry is written within a packet before it is read.
// Configuration is written through wr_en / wr_index / wr_data; the user must
// do so only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module escaped_packet_receiver_checksum_core import epr_pkg::*; #(
	parameter int PKT_MAX = PKT_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	// received byte transactions
	input  logic                 rx_valid,
	output logic                 rx_stall,
	input  logic [7:0]           rx_byte,
	// result transactions
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [15:0]          word_addr,
	output logic [15:0]          data,
	output logic                 end_of_transfer,
	output logic                 last
);

	// command and status between the framing controller and the datapath
	epr_cmd_t  cmd;
	epr_stat_t st;

	// framing controller: hunt, escape, word phases, ack/nak and drain
	epr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: config registers, checksum, payload buffer, output register
	epr_dpath #(
		.PKT_MAX (PKT_MAX)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.rx_byte         (rx_byte),
		.cmd             (cmd),
		.st              (st),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.kind            (kind),
		.word_addr       (word_addr),
		.data            (data),
		.end_of_transfer (end_of_transfer),
		.last            (last)
	);

endmodule
